### design/kua_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed usage accumulator package
// Shared widths and the control state type of the accumulator.
// ----------------------------------------------------------------------------
package kua_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned AMT_W   = 32;
    localparam int unsigned TOT_W   = 32;
    localparam int unsigned OIDX_W  = 6;
    localparam int unsigned S_DATA_W = 64;
    localparam int unsigned M_DATA_W = 40;
    localparam int unsigned M_USER_W = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } t_state;

endpackage

### design/kua_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module kua_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/keyed_usage_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed usage accumulator
// Looks up a card identifier in a table and adds the usage amount to its total.
// ----------------------------------------------------------------------------
//  Channel   Dir  Word contents
//  s_axis    in   tdata: card_id[31:0], amount[63:32]
//  m_axis    out  tdata: entry_index[5:0], running_total[37:6], zero[39:38]
//                 tuser: was_new[0], table_full[1]
//
//  One word is handled at a time, by a sequential scan that reads one stored
//  identifier per cycle. A hit ends the scan early. The reset clears the fill
//  count, the control state, the scan read index, the compare flag and the
//  output valid flag. A finished result waits in a holding stage while the
//  output register is occupied, and a new word is taken once that result has
//  moved into the output register.
// ----------------------------------------------------------------------------
module keyed_usage_accumulator_unit #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // card_id[31:0], amount[63:32]
    input  logic [kua_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // entry_index[5:0], running_total[37:6], zero fill[39:38]
    output logic [kua_pkg::M_DATA_W-1:0]  o_m_axis_tdata,
    // was_new[0], table_full[1]
    output logic [kua_pkg::M_USER_W-1:0]  o_m_axis_tuser
);

    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    kua_pkg::t_state r_state, n_state;
    logic [CW-1:0]  r_fill, n_fill;
    logic [CW-1:0]  r_rd_idx, n_rd_idx;
    logic           r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]  r_cmp_idx, n_cmp_idx;
    logic [kua_pkg::KEY_W-1:0] r_key, n_key;
    logic [kua_pkg::AMT_W-1:0] r_amt, n_amt;

    logic [kua_pkg::OIDX_W-1:0] r_res_idx, n_res_idx;
    logic [kua_pkg::TOT_W-1:0]  r_res_tot, n_res_tot;
    logic                       r_res_new, n_res_new;
    logic                       r_res_full, n_res_full;

    logic                       r_out_vld, n_out_vld;
    logic [kua_pkg::OIDX_W-1:0] r_out_idx, n_out_idx;
    logic [kua_pkg::TOT_W-1:0]  r_out_tot, n_out_tot;
    logic                       r_out_new, n_out_new;
    logic                       r_out_full, n_out_full;

    logic                       id_we, tot_we;
    logic [AW-1:0]              waddr, raddr;
    logic [kua_pkg::TOT_W-1:0]  tot_wdata, tot_sum;
    logic [kua_pkg::KEY_W-1:0]  id_rdata;
    logic [kua_pkg::TOT_W-1:0]  tot_rdata;
    logic                       hit;

    kua_ram #(
        .WIDTH (kua_pkg::KEY_W),
        .DEPTH (ENTRIES)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (waddr),
        .i_wdata (r_key),
        .i_raddr (raddr),
        .o_rdata (id_rdata)
    );

    kua_ram #(
        .WIDTH (kua_pkg::TOT_W),
        .DEPTH (ENTRIES)
    ) u_tot_ram (
        .i_clk   (i_clk),
        .i_we    (tot_we),
        .i_waddr (waddr),
        .i_wdata (tot_wdata),
        .i_raddr (raddr),
        .o_rdata (tot_rdata)
    );

    assign raddr   = r_rd_idx[AW-1:0];
    assign hit     = r_cmp_vld && (id_rdata == r_key);
    assign tot_sum = tot_rdata + r_amt;

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_rd_idx   = r_rd_idx;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_key      = r_key;
        n_amt      = r_amt;
        n_res_idx  = r_res_idx;
        n_res_tot  = r_res_tot;
        n_res_new  = r_res_new;
        n_res_full = r_res_full;
        n_out_vld  = r_out_vld;
        n_out_idx  = r_out_idx;
        n_out_tot  = r_out_tot;
        n_out_new  = r_out_new;
        n_out_full = r_out_full;
        id_we      = 1'b0;
        tot_we     = 1'b0;
        waddr      = r_cmp_idx;
        tot_wdata  = tot_sum;
        o_s_axis_tready = 1'b0;

        if (r_out_vld && i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            kua_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_key     = i_s_axis_tdata[kua_pkg::KEY_W-1:0];
                    n_amt     = i_s_axis_tdata[kua_pkg::KEY_W +: kua_pkg::AMT_W];
                    n_rd_idx  = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = kua_pkg::ST_SCAN;
                end
            end
            kua_pkg::ST_SCAN: begin
                if (r_rd_idx < r_fill) begin
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_idx[AW-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (hit) begin
                    tot_we     = 1'b1;
                    n_res_idx  = kua_pkg::OIDX_W'(r_cmp_idx);
                    n_res_tot  = tot_sum;
                    n_res_new  = 1'b0;
                    n_res_full = 1'b0;
                    n_state    = kua_pkg::ST_HOLD;
                end else if (!r_cmp_vld && (r_rd_idx >= r_fill)) begin
                    n_state = kua_pkg::ST_HOLD;
                    if (r_fill >= FULL_CNT) begin
                        n_res_idx  = '0;
                        n_res_tot  = '0;
                        n_res_new  = 1'b0;
                        n_res_full = 1'b1;
                    end else begin
                        id_we      = 1'b1;
                        tot_we     = 1'b1;
                        waddr      = r_fill[AW-1:0];
                        tot_wdata  = r_amt;
                        n_fill     = r_fill + 1'b1;
                        n_res_idx  = kua_pkg::OIDX_W'(r_fill);
                        n_res_tot  = r_amt;
                        n_res_new  = 1'b1;
                        n_res_full = 1'b0;
                    end
                end
            end
            kua_pkg::ST_HOLD: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_idx  = r_res_idx;
                    n_out_tot  = r_res_tot;
                    n_out_new  = r_res_new;
                    n_out_full = r_res_full;
                    n_state    = kua_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kua_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kua_pkg::ST_IDLE;
            r_fill    <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_rd_idx  <= n_rd_idx;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_key      <= n_key;
        r_amt      <= n_amt;
        r_res_idx  <= n_res_idx;
        r_res_tot  <= n_res_tot;
        r_res_new  <= n_res_new;
        r_res_full <= n_res_full;
        r_out_idx  <= n_out_idx;
        r_out_tot  <= n_out_tot;
        r_out_new  <= n_out_new;
        r_out_full <= n_out_full;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {2'b00, r_out_tot, r_out_idx};
    assign o_m_axis_tuser  = {r_out_full, r_out_new};

endmodule

### sim/tb_keyed_usage_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed usage accumulator testbench
// Drives card words into the accumulator. The words reuse known cards, bring
// new and nearly matching cards, and keep going past the point where the table
// is full. A scoreboard keeps its own copy of the table and checks every
// result word field by field. Both sides idle at random, and once the output
// is held off for a long stretch while cards keep arriving.
// ----------------------------------------------------------------------------
module tb_keyed_usage_accumulator_unit;

    localparam int unsigned ENTRIES     = 64;
    localparam int unsigned RAND_CARDS  = 1080;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [kua_pkg::OIDX_W-1:0] entry;
        logic [kua_pkg::TOT_W-1:0]  total;
        logic                       is_new;
        logic                       full;
    } t_usage_result;

    class t_usage_table_sb;
        logic [kua_pkg::KEY_W-1:0] card_ids[ENTRIES];
        logic [kua_pkg::TOT_W-1:0] usage_totals[ENTRIES];
        int unsigned               cards_held;
        t_usage_result             pending[$];
        int unsigned               errors;

        function new();
            cards_held = 0;
            errors     = 0;
        endfunction

        function void note_card(logic [kua_pkg::KEY_W-1:0] card,
                                logic [kua_pkg::AMT_W-1:0] amt);
            t_usage_result r;
            int            slot;
            slot = -1;
            for (int i = 0; i < cards_held; i++) begin
                if (card_ids[i] == card) begin
                    slot = i;
                    break;
                end
            end
            if (slot >= 0) begin
                usage_totals[slot] = usage_totals[slot] + amt;
                r.entry  = slot[kua_pkg::OIDX_W-1:0];
                r.total  = usage_totals[slot];
                r.is_new = 1'b0;
                r.full   = 1'b0;
            end else if (cards_held >= ENTRIES) begin
                r.entry  = '0;
                r.total  = '0;
                r.is_new = 1'b0;
                r.full   = 1'b1;
            end else begin
                card_ids[cards_held]     = card;
                usage_totals[cards_held] = amt;
                r.entry  = cards_held[kua_pkg::OIDX_W-1:0];
                r.total  = amt;
                r.is_new = 1'b1;
                r.full   = 1'b0;
                cards_held++;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [kua_pkg::M_DATA_W-1:0] data,
                                   logic [kua_pkg::M_USER_W-1:0] user);
            t_usage_result want;
            t_usage_result got;
            got.entry  = data[kua_pkg::OIDX_W-1:0];
            got.total  = data[kua_pkg::OIDX_W +: kua_pkg::TOT_W];
            got.is_new = user[0];
            got.full   = user[1];
            if (pending.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected result word: entry %0d total %h new %b full %b",
                             got.entry, got.total, got.is_new, got.full);
                end
                return;
            end
            want = pending.pop_front();
            if (got.entry != want.entry || got.total != want.total ||
                got.is_new != want.is_new || got.full != want.full) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("mismatch at %0t: entry exp %0d got %0d, total exp %h got %h",
                             $realtime, want.entry, got.entry, want.total, got.total);
                    $display("    new exp %b got %b, full exp %b got %b",
                             want.is_new, got.is_new, want.full, got.full);
                end
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         card_tvalid;
    logic                         card_tready;
    logic [kua_pkg::S_DATA_W-1:0] card_tdata;
    logic                         usage_tvalid;
    logic                         usage_tready;
    logic [kua_pkg::M_DATA_W-1:0] usage_tdata;
    logic [kua_pkg::M_USER_W-1:0] usage_tuser;

    int unsigned               tx_idle_pct;
    int unsigned               rx_idle_pct;
    logic                      rx_hold;
    event                      rx_hold_ev;
    logic [kua_pkg::KEY_W-1:0] known_cards[$];
    t_usage_table_sb           sb;

    keyed_usage_accumulator_unit #(
        .ENTRIES(ENTRIES)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(card_tvalid),
        .o_s_axis_tready(card_tready),
        .i_s_axis_tdata (card_tdata),
        .o_m_axis_tvalid(usage_tvalid),
        .i_m_axis_tready(usage_tready),
        .o_m_axis_tdata (usage_tdata),
        .o_m_axis_tuser (usage_tuser)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rx_hold) begin
            usage_tready <= 1'b0;
        end else begin
            usage_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always begin
        @(rx_hold_ev);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && usage_tvalid && usage_tready) begin
            sb.check_result(usage_tdata, usage_tuser);
        end
    end

    task automatic send_card(input logic [kua_pkg::KEY_W-1:0] card,
                             input logic [kua_pkg::AMT_W-1:0] amt);
        while ($urandom_range(99) < tx_idle_pct) begin
            card_tvalid <= 1'b0;
            @(posedge clk);
        end
        card_tvalid <= 1'b1;
        card_tdata  <= {amt, card};
        @(posedge clk);
        while (!card_tready) @(posedge clk);
        sb.note_card(card, amt);
        known_cards.push_back(card);
    endtask

    function automatic logic [kua_pkg::KEY_W-1:0] pick_card();
        int unsigned               r;
        logic [kua_pkg::KEY_W-1:0] c;
        r = $urandom_range(99);
        c = known_cards[$urandom_range(known_cards.size() - 1)];
        if (r < 8) begin
            c = $urandom;
        end else if (r < 12) begin
            c[$urandom_range(kua_pkg::KEY_W - 1)] = ~c[$urandom_range(kua_pkg::KEY_W - 1)];
            c = c ^ (32'h1 << $urandom_range(kua_pkg::KEY_W - 1));
        end else if (r < 14) begin
            c = 32'h1 << $urandom_range(kua_pkg::KEY_W - 1);
        end
        return c;
    endfunction

    function automatic logic [kua_pkg::AMT_W-1:0] pick_amount();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) begin
            return $urandom;
        end else if (r < 25) begin
            return 32'hFFFF_FF00 | $urandom_range(255);
        end else begin
            return $urandom_range(5000);
        end
    endfunction

    initial begin
        sb           = new();
        rst_n        = 1'b0;
        card_tvalid  = 1'b0;
        card_tdata   = '0;
        usage_tready = 1'b0;
        rx_hold      = 1'b0;
        tx_idle_pct  = 38;
        rx_idle_pct  = 77;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of both fields, wrapping totals and keys that differ by one bit.
        send_card(32'h0000_0000, 32'h0000_0000);
        send_card(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_card(32'hFFFF_FFFF, 32'h0000_0001);
        send_card(32'h0000_0000, 32'hFFFF_FFFF);
        send_card(32'h0000_0001, 32'h0000_0005);
        send_card(32'h8000_0000, 32'h8000_0000);
        send_card(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_card(32'hFFFF_FFFE, 32'h0000_0000);
        send_card(32'h8000_0000, 32'h8000_0000);
        send_card(32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_card(32'h5A5A_5A5A, 32'hA5A5_A5A5);
        send_card(32'h0000_0000, 32'h0000_0001);
        send_card(32'hA5A5_A5A5, 32'hA5A5_A5A5);
        send_card(32'h0000_0001, 32'hFFFF_FFFB);

        for (int n = 0; n < RAND_CARDS; n++) begin
            if (n == RAND_CARDS / 3) begin
                tx_idle_pct = 77;
                rx_idle_pct = 38;
            end else if (n == 2 * RAND_CARDS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                -> rx_hold_ev;
            end
            send_card(pick_card(), pick_amount());
        end
        card_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("FAILURE");
        $finish;
    end

endmodule
